// ----- rtl/c8ex_pkg.sv -----
// c8ex_pkg: shared types, command codes and execute function for the chip8 execute unit
// no dependencies; imported by every module of the block

package c8ex_pkg;

   // sizes and fixed constants
   localparam int          STACK_DEPTH_DEF = 16;
   localparam int          REG_COUNT       = 16;
   localparam int          REG_AW          = 4;
   localparam int          ADDR_W          = 12;
   localparam int          BYTE_W          = 8;
   localparam int          LEVEL_W         = 5;
   localparam logic [3:0]  FLAG_REG        = 4'hF;
   localparam logic [11:0] PC_SKIP_STEP    = 12'd2;

   // decoded instruction codes
   typedef enum logic [4:0] {
      CMD_RET      = 5'd0,
      CMD_JP       = 5'd1,
      CMD_CALL     = 5'd2,
      CMD_SE_IMM   = 5'd3,
      CMD_SNE_IMM  = 5'd4,
      CMD_SE_REG   = 5'd5,
      CMD_LD_IMM   = 5'd6,
      CMD_ADD_IMM  = 5'd7,
      CMD_LD_REG   = 5'd8,
      CMD_OR       = 5'd9,
      CMD_AND      = 5'd10,
      CMD_XOR      = 5'd11,
      CMD_ADD_REG  = 5'd12,
      CMD_SUB      = 5'd13,
      CMD_SHR      = 5'd14,
      CMD_SUBN     = 5'd15,
      CMD_SHL      = 5'd16,
      CMD_SNE_REG  = 5'd17,
      CMD_LD_INDEX = 5'd18
   } cmd_type;

   // fault codes
   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_OVERFLOW  = 2'd1,
      FAULT_UNDERFLOW = 2'd2
   } fault_type;

   // register file write port
   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [BYTE_W-1:0] data;
   } rf_write_type;

   // stack control and status
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } stack_sts_type;

   // outcome of the register operations
   typedef struct packed {
      logic              reg_we;
      logic [BYTE_W-1:0] reg_data;
      logic              flag_we;
      logic [BYTE_W-1:0] flag_data;
      logic              skip;
   } alu_res_type;

   // register operations; gx and gy are the values before the instruction.
   // sub, subn and shifts see register 15 after the flag write,
   // add with carry sees it before
   function automatic alu_res_type exec_alu(input cmd_type           cmd,
                                            input logic              x_is_flag,
                                            input logic              y_is_flag,
                                            input logic [BYTE_W-1:0] gx,
                                            input logic [BYTE_W-1:0] gy,
                                            input logic [BYTE_W-1:0] kk);
      alu_res_type       res;
      logic [BYTE_W:0]   sum;
      logic [BYTE_W-1:0] a0;
      logic [BYTE_W-1:0] b0;
      logic [BYTE_W-1:0] a1;
      logic [BYTE_W-1:0] b1;
      logic              f;
      res = '0;
      sum = '0;
      // operands once the flag has been cleared
      a0  = x_is_flag ? '0 : gx;
      b0  = y_is_flag ? '0 : gy;
      f   = 1'b0;
      a1  = gx;
      b1  = gy;
      unique case (cmd)
         CMD_SE_IMM:  res.skip = (gx == kk);
         CMD_SNE_IMM: res.skip = (gx != kk);
         CMD_SE_REG:  res.skip = (gx == gy);
         CMD_SNE_REG: res.skip = (gx != gy);
         CMD_LD_IMM: begin
            res.reg_we   = 1'b1;
            res.reg_data = kk;
         end
         CMD_ADD_IMM: begin
            res.reg_we   = 1'b1;
            res.reg_data = gx + kk;
         end
         CMD_LD_REG: begin
            res.reg_we   = 1'b1;
            res.reg_data = gy;
         end
         CMD_OR: begin
            res.reg_we   = 1'b1;
            res.reg_data = gx | gy;
         end
         CMD_AND: begin
            res.reg_we   = 1'b1;
            res.reg_data = gx & gy;
         end
         CMD_XOR: begin
            res.reg_we   = 1'b1;
            res.reg_data = gx ^ gy;
         end
         CMD_ADD_REG: begin
            sum           = {1'b0, gx} + {1'b0, gy};
            res.flag_we   = 1'b1;
            res.flag_data = {{(BYTE_W-1){1'b0}}, sum[BYTE_W]};
            res.reg_we    = 1'b1;
            res.reg_data  = sum[BYTE_W-1:0];
         end
         CMD_SUB: begin
            f             = (a0 > b0);
            a1            = x_is_flag ? {{(BYTE_W-1){1'b0}}, f} : gx;
            b1            = y_is_flag ? {{(BYTE_W-1){1'b0}}, f} : gy;
            res.flag_we   = 1'b1;
            res.flag_data = {{(BYTE_W-1){1'b0}}, f};
            res.reg_we    = 1'b1;
            res.reg_data  = a1 - b1;
         end
         CMD_SUBN: begin
            f             = (b0 > a0);
            a1            = x_is_flag ? {{(BYTE_W-1){1'b0}}, f} : gx;
            b1            = y_is_flag ? {{(BYTE_W-1){1'b0}}, f} : gy;
            res.flag_we   = 1'b1;
            res.flag_data = {{(BYTE_W-1){1'b0}}, f};
            res.reg_we    = 1'b1;
            res.reg_data  = b1 - a1;
         end
         CMD_SHR: begin
            f             = gx[0];
            a1            = x_is_flag ? {{(BYTE_W-1){1'b0}}, f} : gx;
            res.flag_we   = 1'b1;
            res.flag_data = {{(BYTE_W-1){1'b0}}, f};
            res.reg_we    = 1'b1;
            res.reg_data  = {1'b0, a1[BYTE_W-1:1]};
         end
         CMD_SHL: begin
            f             = gx[BYTE_W-1];
            a1            = x_is_flag ? {{(BYTE_W-1){1'b0}}, f} : gx;
            res.flag_we   = 1'b1;
            res.flag_data = {{(BYTE_W-1){1'b0}}, f};
            res.reg_we    = 1'b1;
            res.reg_data  = {a1[BYTE_W-2:0], 1'b0};
         end
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

// ----- rtl/c8ex_regfile.sv -----
// c8ex_regfile: general register storage for the chip8 execute unit
// depends on c8ex_pkg; registered reads with forwarding from the write port

module c8ex_regfile import c8ex_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [REG_AW-1:0]   rd_addr_x,
   input  logic [REG_AW-1:0]   rd_addr_y,
   input  rf_write_type        wr,
   output logic [BYTE_W-1:0]   rd_data_x,
   output logic [BYTE_W-1:0]   rd_data_y
);

   logic [BYTE_W-1:0]    mem [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [REG_COUNT-1:0] vld_in;
   logic [BYTE_W-1:0]    raw_x_ff;
   logic [BYTE_W-1:0]    raw_y_ff;
   logic                 vld_x_ff;
   logic                 vld_y_ff;
   logic                 fwd_x_ff;
   logic                 fwd_y_ff;
   logic [BYTE_W-1:0]    fwd_data_ff;

   // entry valid bits, an unwritten entry reads as zero
   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // storage array, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      raw_x_ff <= mem[rd_addr_x];
      raw_y_ff <= mem[rd_addr_y];
   end

   // read qualifiers and forwarding of a same-cycle write
   always_ff @(posedge clock) begin
      vld_x_ff    <= vld_ff[rd_addr_x];
      vld_y_ff    <= vld_ff[rd_addr_y];
      fwd_x_ff    <= wr.en && (wr.addr == rd_addr_x);
      fwd_y_ff    <= wr.en && (wr.addr == rd_addr_y);
      fwd_data_ff <= wr.data;
   end

   // read data selection
   always_comb begin
      rd_data_x = fwd_x_ff ? fwd_data_ff : (vld_x_ff ? raw_x_ff : '0);
      rd_data_y = fwd_y_ff ? fwd_data_ff : (vld_y_ff ? raw_y_ff : '0);
   end

endmodule

// ----- rtl/c8ex_stack.sv -----
// c8ex_stack: return address stack of the chip8 execute unit
// depends on c8ex_pkg; top entry in a register, the rest in a memory with a prefetched entry below

module c8ex_stack import c8ex_pkg::*; #(
   parameter int DEPTH = STACK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  stack_ctl_type                     ctl,
   input  logic [ADDR_W-1:0]                 push_data,
   output logic [ADDR_W-1:0]                 top_data,
   output logic [$clog2(DEPTH+1)-1:0]        level_next,
   output stack_sts_type                     sts
);

   localparam int SP_W = $clog2(DEPTH + 1);
   localparam int AW   = $clog2(DEPTH);

   logic [ADDR_W-1:0] mem [DEPTH];
   logic [SP_W-1:0]   sp_ff;
   logic [SP_W-1:0]   sp_in;
   logic [ADDR_W-1:0] tos_ff;
   logic [ADDR_W-1:0] below_ff;
   logic [SP_W-1:0]   wr_ptr;
   logic [SP_W-1:0]   rd_ptr;
   logic              mem_we;
   logic              rd_en;

   // pointer update
   always_comb begin
      priority if (ctl.push) begin
         sp_in = sp_ff + SP_W'(1);
      end else if (ctl.pop) begin
         sp_in = sp_ff - SP_W'(1);
      end else begin
         sp_in = sp_ff;
      end
      // old top spills into the memory on a push
      wr_ptr = sp_ff - SP_W'(1);
      mem_we = ctl.push && (sp_ff != '0);
      // entry just below the new top
      rd_ptr = sp_in - SP_W'(2);
      rd_en  = (sp_in > SP_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // top of stack register
   always_ff @(posedge clock) begin
      priority if (ctl.push) begin
         tos_ff <= push_data;
      end else if (ctl.pop) begin
         tos_ff <= below_ff;
      end else begin
         tos_ff <= tos_ff;
      end
   end

   // memory and prefetch of the entry below the top
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr[AW-1:0]] <= tos_ff;
      end
      priority if (ctl.push) begin
         below_ff <= tos_ff;
      end else if (rd_en) begin
         below_ff <= mem[rd_ptr[AW-1:0]];
      end else begin
         below_ff <= below_ff;
      end
   end

   assign top_data   = tos_ff;
   assign level_next = sp_in;
   assign sts.full   = (sp_ff == SP_W'(DEPTH));
   assign sts.empty  = (sp_ff == '0);

endmodule

// ----- rtl/chip8_execute_unit.sv -----
// chip8_execute_unit: top level of the chip8 instruction execute block
// depends on c8ex_pkg, c8ex_regfile and c8ex_stack

// One decoded instruction is taken per clock: busy never rises, so an
// instruction transfer happens at every clock edge with start high. The
// instruction is registered on entry, executed against the register file,
// program counter, index register and return stack in the following cycle,
// and its result is strobed on rsp_valid for one cycle from the result
// register behind execute. Results follow each other at the same rate and
// cannot be held off, so the receiver must take every strobed result.
// Throughput is one instruction per cycle, set by the single execute stage;
// the register file and stack memories are read ahead into registers, with
// forwarding of the write made by the instruction in execute. Faulting
// calls and returns change no state.

module chip8_execute_unit import c8ex_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [4:0]          req_command,
   input  logic [3:0]          req_reg_x,
   input  logic [3:0]          req_reg_y,
   input  logic [ADDR_W-1:0]   req_immediate,
   output logic                rsp_valid,
   output logic [ADDR_W-1:0]   rsp_prog_counter,
   output logic [ADDR_W-1:0]   rsp_index_addr,
   output logic [BYTE_W-1:0]   rsp_dest_value,
   output logic [BYTE_W-1:0]   rsp_flag_value,
   output logic [LEVEL_W-1:0]  rsp_stack_level,
   output logic [1:0]          rsp_fault
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);

   logic                 valid_ff;
   cmd_type              cmd_ff;
   logic [REG_AW-1:0]    x_ff;
   logic [REG_AW-1:0]    y_ff;
   logic [ADDR_W-1:0]    imm_ff;

   logic [ADDR_W-1:0]    pc_ff;
   logic [ADDR_W-1:0]    pc_in;
   logic [ADDR_W-1:0]    index_ff;
   logic [ADDR_W-1:0]    index_in;
   logic [BYTE_W-1:0]    flag_ff;
   logic [BYTE_W-1:0]    flag_in;

   logic [BYTE_W-1:0]    rf_x;
   logic [BYTE_W-1:0]    rf_y;
   rf_write_type         rf_wr;

   stack_ctl_type        stk_ctl;
   stack_sts_type        stk_sts;
   logic [ADDR_W-1:0]    stk_top;
   logic [SP_W-1:0]      stk_level;
   logic [SP_W+LEVEL_W-1:0] level_wide;

   logic                 x_is_flag;
   logic                 y_is_flag;
   logic [BYTE_W-1:0]    gx;
   logic [BYTE_W-1:0]    gy;
   alu_res_type          alu;
   fault_type            fault_cur;
   logic [BYTE_W-1:0]    dest_after;
   logic [BYTE_W-1:0]    flag_after;

   logic                 rsp_valid_ff;
   logic [ADDR_W-1:0]    rsp_pc_ff;
   logic [ADDR_W-1:0]    rsp_index_ff;
   logic [BYTE_W-1:0]    rsp_dest_ff;
   logic [BYTE_W-1:0]    rsp_flag_ff;
   logic [LEVEL_W-1:0]   rsp_level_ff;
   fault_type            rsp_fault_ff;

   assign busy = 1'b0;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_type'(req_command);
      x_ff   <= req_reg_x;
      y_ff   <= req_reg_y;
      imm_ff <= req_immediate;
   end

   // general registers, read while the instruction enters
   c8ex_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_x (req_reg_x),
      .rd_addr_y (req_reg_y),
      .wr        (rf_wr),
      .rd_data_x (rf_x),
      .rd_data_y (rf_y)
   );

   // return stack
   c8ex_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .ctl        (stk_ctl),
      .push_data  (pc_ff),
      .top_data   (stk_top),
      .level_next (stk_level),
      .sts        (stk_sts)
   );

   // execute stage
   always_comb begin
      x_is_flag = (x_ff == FLAG_REG);
      y_is_flag = (y_ff == FLAG_REG);
      gx        = x_is_flag ? flag_ff : rf_x;
      gy        = y_is_flag ? flag_ff : rf_y;
      alu       = exec_alu(cmd_ff, x_is_flag, y_is_flag, gx, gy, imm_ff[BYTE_W-1:0]);

      // stack operations and faults
      stk_ctl.push = valid_ff && (cmd_ff == CMD_CALL) && !stk_sts.full;
      stk_ctl.pop  = valid_ff && (cmd_ff == CMD_RET) && !stk_sts.empty;
      priority if ((cmd_ff == CMD_CALL) && stk_sts.full) begin
         fault_cur = FAULT_OVERFLOW;
      end else if ((cmd_ff == CMD_RET) && stk_sts.empty) begin
         fault_cur = FAULT_UNDERFLOW;
      end else begin
         fault_cur = FAULT_NONE;
      end

      // program counter and index
      priority if (stk_ctl.pop) begin
         pc_in = stk_top;
      end else if (stk_ctl.push || (valid_ff && (cmd_ff == CMD_JP))) begin
         pc_in = imm_ff;
      end else if (valid_ff && alu.skip) begin
         pc_in = pc_ff + PC_SKIP_STEP;
      end else begin
         pc_in = pc_ff;
      end
      index_in = (valid_ff && (cmd_ff == CMD_LD_INDEX)) ? imm_ff : index_ff;

      // register values after the flag write then the destination write
      flag_after = alu.flag_we ? alu.flag_data : flag_ff;
      if (alu.reg_we && x_is_flag) begin
         flag_after = alu.reg_data;
      end
      dest_after = alu.reg_we ? alu.reg_data : (x_is_flag ? flag_after : gx);
      flag_in    = valid_ff ? flag_after : flag_ff;

      rf_wr.en   = valid_ff && alu.reg_we && !x_is_flag;
      rf_wr.addr = x_ff;
      rf_wr.data = alu.reg_data;

      level_wide = {{LEVEL_W{1'b0}}, stk_level};
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         index_ff <= '0;
         flag_ff  <= '0;
      end else begin
         pc_ff    <= pc_in;
         index_ff <= index_in;
         flag_ff  <= flag_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_ff) begin
         rsp_pc_ff    <= pc_in;
         rsp_index_ff <= index_in;
         rsp_dest_ff  <= dest_after;
         rsp_flag_ff  <= flag_after;
         rsp_level_ff <= level_wide[LEVEL_W-1:0];
         rsp_fault_ff <= fault_cur;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prog_counter = rsp_pc_ff;
   assign rsp_index_addr   = rsp_index_ff;
   assign rsp_dest_value   = rsp_dest_ff;
   assign rsp_flag_value   = rsp_flag_ff;
   assign rsp_stack_level  = rsp_level_ff;
   assign rsp_fault        = rsp_fault_ff;

endmodule

// ----- rtl/c8ex_checker.sv -----
// c8ex_checker: port-level checks for the chip8 execute unit
// depends on c8ex_pkg; bound to chip8_execute_unit at the end of this file

module c8ex_checker import c8ex_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [4:0]         req_command,
   input logic               rsp_valid,
   input logic [LEVEL_W-1:0] rsp_stack_level,
   input logic [1:0]         rsp_fault
);

   // every instruction transfer gives a result strobe
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("instruction transfer without a result");

   // no result without an instruction transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##2 !rsp_valid)
      else $error("result strobe without an instruction");

   // only calls and returns fault
   a_fault_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_fault != FAULT_NONE)) |->
      (($past(req_command, 2) == CMD_RET) || ($past(req_command, 2) == CMD_CALL)))
      else $error("fault reported for an instruction other than call or return");

   // underflow only on an empty stack
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_fault == FAULT_UNDERFLOW)) |-> (rsp_stack_level == '0))
      else $error("underflow reported with a non-empty stack");

endmodule

bind chip8_execute_unit c8ex_checker u_c8ex_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_command     (req_command),
   .rsp_valid       (rsp_valid),
   .rsp_stack_level (rsp_stack_level),
   .rsp_fault       (rsp_fault)
);
